@@ rtl/ecdf_pkg.sv @@
// Shared types and constants for the event cooldown dedup filter.
package ecdf_pkg;

	localparam int unsigned RING_DEPTH_DEF = 64;
	localparam int unsigned ID_W           = 32;
	localparam int unsigned TS_W           = 63;
	localparam int unsigned COOL_W         = 48;
	localparam logic [COOL_W-1:0] COOL_RESET = 48'd7000;

	// One remembered event; a zero stamp marks an empty entry
	typedef struct packed {
		logic [ID_W-1:0] caller;
		logic [ID_W-1:0] target;
		logic            kind;
		logic [TS_W-1:0] stamp;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

@@ rtl/ecdf_ring_mem.sv @@
// Event ring storage: one write port, one registered read port.
module ecdf_ring_mem #(
	parameter int unsigned DEPTH = ecdf_pkg::RING_DEPTH_DEF,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  ecdf_pkg::entry_t      wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output ecdf_pkg::entry_t      rdata
);

	ecdf_pkg::entry_t mem [DEPTH];
	ecdf_pkg::entry_t rdata_q;

	// Write the slot chosen by the ring pointer
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read one entry, data valid the next cycle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/ecdf_scan.sv @@
// Scan sequencer: walks the ring, compares entries, records allowed events.
module ecdf_scan #(
	parameter int unsigned DEPTH = ecdf_pkg::RING_DEPTH_DEF,
	localparam int unsigned AW = $clog2(DEPTH),
	localparam int unsigned FW = $clog2(DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ecdf_pkg::COOL_W-1:0]   cooldown,
	// event input beat
	input  logic                          ev_valid,
	output logic                          ev_ready,
	input  ecdf_pkg::entry_t              ev_data,
	// result beat
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic                          res_allow,
	// ring memory port
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_waddr,
	output ecdf_pkg::entry_t              mem_wdata,
	output logic                          mem_re,
	output logic [AW-1:0]                 mem_raddr,
	input  ecdf_pkg::entry_t              mem_rdata
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} scan_state_t;

	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [FW-1:0] FULL_CNT = FW'(DEPTH);

	scan_state_t      state_q;
	ecdf_pkg::entry_t ev_q;
	logic [AW-1:0]    idx_q;
	logic [AW-1:0]    slot_q;
	logic [FW-1:0]    fill_q;
	logic             hit_q;
	logic             rd_valid_s1;
	logic [AW-1:0]    ridx_s1;
	logic             out_valid_q;
	logic             allow_q;

	logic                      ev_fire;
	logic                      finish;
	logic                      match;
	logic [ecdf_pkg::TS_W-1:0] age;

	assign ev_ready = (state_q == ST_IDLE);
	assign ev_fire  = ev_valid && ev_ready;
	assign finish   = (state_q == ST_DONE) && (!out_valid_q || res_ready);

	// Compare the entry read last cycle against the held event
	assign age = ev_q.stamp - mem_rdata.stamp;
	always_comb begin
		match = rd_valid_s1
			&& (FW'(ridx_s1) < fill_q)
			&& (mem_rdata.stamp != '0)
			&& (mem_rdata.caller == ev_q.caller)
			&& (mem_rdata.target == ev_q.target)
			&& (mem_rdata.kind == ev_q.kind)
			&& (mem_rdata.stamp <= ev_q.stamp)
			&& (age < ecdf_pkg::TS_W'(cooldown));
	end

	// Sequence the scan and update the ring pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			slot_q      <= '0;
			fill_q      <= '0;
			hit_q       <= 1'b0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == ST_SCAN);
			if (ev_fire) begin
				hit_q <= 1'b0;
			end else if (match) begin
				hit_q <= 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && res_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (ev_fire) begin
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (finish) begin
						state_q <= ST_IDLE;
						if (!hit_q) begin
							slot_q <= (slot_q == LAST_IDX) ? '0 : slot_q + 1'b1;
							if (fill_q != FULL_CNT) begin
								fill_q <= fill_q + 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the event, pipeline the read index and register the allow bit
	always_ff @(posedge clk) begin
		if (ev_fire) begin
			ev_q <= ev_data;
		end
		ridx_s1 <= idx_q;
		if (finish) begin
			allow_q <= !hit_q;
		end
	end

	assign mem_re    = (state_q == ST_SCAN);
	assign mem_raddr = idx_q;
	assign mem_we    = finish && !hit_q;
	assign mem_waddr = slot_q;
	assign mem_wdata = ev_q;

	assign res_valid = out_valid_q;
	assign res_allow = allow_q;

endmodule

@@ rtl/event_cooldown_dedup_filter_top.sv @@
// Top level of the event cooldown dedup filter.
//
// Usage: each input beat on s_* is one event (caller, target, kind, now).
// The block scans every slot of an event ring and answers with one beat on
// m_* whose bit 0 is allow: 1 when no remembered event with the same caller,
// target and kind lies less than cooldown ticks in the past (and not in the
// future), 0 when the event is suppressed. Allowed events overwrite the next
// ring slot in round-robin order.
// Flow: the result beat follows a walk over every ring slot, one read per
// cycle of the ring memory; no new event is taken until the previous one
// has been scanned and its result registered.
// Reset: the ring counts as empty at once through a fill count (no clearing
// pass), the ring pointer returns to slot 0 and cooldown to 7000 ticks.
// Stall: the result waits in an output register while m_tready is low; the
// next event is still taken and scanned, and its result waits until the
// previous beat has left.
// cfg_we writes cfg_wdata into the cooldown register; write only when idle.
module event_cooldown_dedup_filter_top #(
	parameter int unsigned RING_DEPTH = ecdf_pkg::RING_DEPTH_DEF,
	localparam int unsigned AW = $clog2(RING_DEPTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ecdf_pkg::COOL_W-1:0] cfg_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [127:0]                s_tdata,  // caller_id, target_id, now_ticks, pad
	input  logic [0:0]                  s_tuser,  // event_kind
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata   // allow, pad
);

	logic [ecdf_pkg::COOL_W-1:0] cooldown_q;
	ecdf_pkg::entry_t            ev_data;
	logic                        allow;
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	ecdf_pkg::entry_t            mem_wdata;
	logic                        mem_re;
	logic [AW-1:0]               mem_raddr;
	ecdf_pkg::entry_t            mem_rdata;

	// Hold the cooldown register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooldown_q <= ecdf_pkg::COOL_RESET;
		end else if (cfg_we) begin
			cooldown_q <= cfg_wdata;
		end
	end

	// Unpack the input beat
	always_comb begin
		ev_data.caller = s_tdata[31:0];
		ev_data.target = s_tdata[63:32];
		ev_data.kind   = s_tuser[0];
		ev_data.stamp  = s_tdata[126:64];
	end

	ecdf_scan #(
		.DEPTH (RING_DEPTH)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cooldown  (cooldown_q),
		.ev_valid  (s_tvalid),
		.ev_ready  (s_tready),
		.ev_data   (ev_data),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_allow (allow),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	ecdf_ring_mem #(
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign m_tdata = {7'b0, allow};

endmodule

@@ bench/event_cooldown_dedup_filter_top_tb.sv @@
// Testbench for the event cooldown dedup filter: directed and random events against a predictor.
`timescale 1ns / 100ps

module event_cooldown_dedup_filter_top_tb;

	localparam int unsigned RING_DEPTH  = ecdf_pkg::RING_DEPTH_DEF;
	localparam int unsigned HOLD_CYCLES = 500;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned POOL_SIZE   = 6;

	localparam logic KIND_REMOTE_CALL   = 1'b0;
	localparam logic KIND_THREAD_HIJACK = 1'b1;

	localparam logic [ecdf_pkg::COOL_W-1:0] COOL_MAX = '1;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_we;
	logic [ecdf_pkg::COOL_W-1:0] cfg_wdata;
	logic                        s_tvalid;
	logic                        s_tready;
	logic [127:0]                s_tdata;   // caller_id, target_id, now_ticks, pad
	logic [0:0]                  s_tuser;   // event_kind
	logic                        m_tvalid;
	logic                        m_tready;
	logic [7:0]                  m_tdata;   // allow, pad

	// Predictor state: remembered events, write pointer, active window
	ecdf_pkg::entry_t            seen_events [RING_DEPTH];
	int unsigned                 seen_wr_ptr;
	logic [ecdf_pkg::COOL_W-1:0] cooldown_win;

	// Allow bits still owed by the block, oldest first
	logic allow_due [$];

	int  err_count;
	int  sent_cnt;
	int  allowed_cnt;
	int  suppressed_cnt;
	int  window_cnt;
	int  dead_cycles;
	bit  tx_quiet;
	bit  rx_quiet;
	bit  hold_req;

	event_cooldown_dedup_filter_top #(
		.RING_DEPTH(RING_DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Decide one event against the remembered ring and record it if allowed
	function automatic logic judge_event(input logic [ecdf_pkg::ID_W-1:0] caller,
			input logic [ecdf_pkg::ID_W-1:0] target, input logic kind,
			input logic [ecdf_pkg::TS_W-1:0] now);
		ecdf_pkg::entry_t e;
		logic             hit;
		int unsigned      k;
		hit = 1'b0;
		for (k = 0; k < RING_DEPTH; k++) begin
			e = seen_events[k];
			if (e.stamp != '0 && e.caller == caller && e.target == target &&
					e.kind == kind && e.stamp <= now &&
					(now - e.stamp) <
					{{(ecdf_pkg::TS_W-ecdf_pkg::COOL_W){1'b0}}, cooldown_win})
				hit = 1'b1;
		end
		if (!hit) begin
			seen_events[seen_wr_ptr] = '{caller: caller, target: target, kind: kind, stamp: now};
			seen_wr_ptr = (seen_wr_ptr + 1) % RING_DEPTH;
		end
		return !hit;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [ecdf_pkg::TS_W-1:0] rand_stamp();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[ecdf_pkg::TS_W-1:0];
	endfunction

	// Offer one event beat and hold it until taken
	task automatic send_event(input logic [ecdf_pkg::ID_W-1:0] caller,
			input logic [ecdf_pkg::ID_W-1:0] target,
			input logic kind, input logic [ecdf_pkg::TS_W-1:0] now);
		int gap;
		gap = tx_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, now, target, caller};
		s_tuser  <= kind;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		allow_due.push_back(judge_event(caller, target, kind, now));
		sent_cnt++;
	endtask

	// Drain all owed results, then write the window while the block is idle
	task automatic set_cooldown(input logic [ecdf_pkg::COOL_W-1:0] value);
		s_tvalid <= 1'b0;
		while (allow_due.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cooldown_win = value;
		window_cnt++;
	endtask

	// Reset window: boundary, future stamps, extreme fields, zero stamp
	task automatic test_default_window();
		// pair seen at 100 stays suppressed through 7099 and clears at 7100
		send_event(32'h0, 32'h0, KIND_REMOTE_CALL, 63'd100);
		send_event(32'h0, 32'h0, KIND_REMOTE_CALL, 63'd100);
		send_event(32'h0, 32'h0, KIND_REMOTE_CALL, 63'd7099);
		send_event(32'h0, 32'h0, KIND_REMOTE_CALL, 63'd7100);
		// stored stamps lie ahead of now, so none may match
		send_event(32'h0, 32'h0, KIND_REMOTE_CALL, 63'd50);
		// all-ones ids and stamp, then one field changed at a time
		send_event('1, '1, KIND_THREAD_HIJACK, '1);
		send_event('1, '1, KIND_THREAD_HIJACK, '1);
		send_event('1, '1, KIND_REMOTE_CALL, '1);
		send_event(32'hFFFF_FFFE, '1, KIND_THREAD_HIJACK, '1);
		send_event('1, 32'h7FFF_FFFF, KIND_THREAD_HIJACK, '1);
		// an event at stamp zero leaves an empty entry behind
		send_event(32'd5, 32'd6, KIND_REMOTE_CALL, 63'd0);
		send_event(32'd5, 32'd6, KIND_REMOTE_CALL, 63'd0);
		send_event(32'd5, 32'd6, KIND_REMOTE_CALL, 63'd1);
		send_event(32'd5, 32'd6, KIND_REMOTE_CALL, 63'd1);
	endtask

	// Zero window: identical events all pass
	task automatic test_zero_window();
		set_cooldown('0);
		repeat (3) send_event(32'd9, 32'd9, KIND_THREAD_HIJACK, 63'd1000);
	endtask

	// Widest window: suppress right below the edge, allow at it
	task automatic test_max_window();
		set_cooldown(COOL_MAX);
		send_event(32'hA5A5_0001, 32'h5A5A_0002, KIND_REMOTE_CALL, 63'd1);
		send_event(32'hA5A5_0001, 32'h5A5A_0002, KIND_REMOTE_CALL, 63'h0000_FFFF_FFFF_FFFF);
		send_event(32'hA5A5_0001, 32'h5A5A_0002, KIND_REMOTE_CALL, 63'h0001_0000_0000_0000);
		send_event(32'hA5A5_0001, 32'h5A5A_0002, KIND_REMOTE_CALL, 63'h0001_0000_0000_0001);
	endtask

	// Hold the result side off long enough that the input backs up
	task automatic test_output_backpressure();
		int                        i;
		logic [ecdf_pkg::TS_W-1:0] stamp;
		set_cooldown(48'd7000);
		tx_quiet = 1'b1;
		hold_req = 1'b1;
		stamp = rand_stamp();
		for (i = 0; i < 8; i++) begin
			send_event($urandom, $urandom, 1'($urandom_range(0, 1)), stamp);
			stamp = stamp + 63'd10;
		end
		tx_quiet = 1'b0;
	endtask

	// Traffic from a few recurring pairs plus near misses and noise
	task automatic test_random_traffic(input logic [ecdf_pkg::COOL_W-1:0] window,
			input int count, input bit quiet);
		logic [ecdf_pkg::ID_W-1:0] pool_caller [POOL_SIZE];
		logic [ecdf_pkg::ID_W-1:0] pool_target [POOL_SIZE];
		logic                      pool_kind   [POOL_SIZE];
		logic [ecdf_pkg::TS_W-1:0] pool_last   [POOL_SIZE];
		logic [ecdf_pkg::TS_W-1:0] clock_now;
		logic [ecdf_pkg::TS_W-1:0] stamp;
		logic [63:0]               span;
		logic [63:0]               step;
		logic [ecdf_pkg::ID_W-1:0] c;
		logic [ecdf_pkg::ID_W-1:0] t;
		logic                      k;
		int                        i;
		int                        p;
		int                        r;
		set_cooldown(window);
		tx_quiet = quiet;
		rx_quiet = quiet;
		for (i = 0; i < POOL_SIZE; i++) begin
			pool_caller[i] = $urandom;
			pool_target[i] = $urandom;
			pool_kind[i]   = 1'($urandom_range(0, 1));
			pool_last[i]   = '0;
		end
		clock_now = rand_stamp();
		span = (window == '0) ? 64'd16 : {16'b0, window};
		for (i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			p = $urandom_range(0, POOL_SIZE - 1);
			c = pool_caller[p];
			t = pool_target[p];
			k = pool_kind[p];
			if (r < 10) begin
				// land on or just inside the edge of this pair's window
				clock_now = pool_last[p] + span[ecdf_pkg::TS_W-1:0]
					- ecdf_pkg::TS_W'($urandom_range(0, 1));
			end else if (r < 65) begin
				step = {$urandom, $urandom} % (span + span / 2 + 64'd1);
				if ($urandom_range(0, 4) == 0)
					step = '0;
				clock_now = clock_now + step[ecdf_pkg::TS_W-1:0];
			end else if (r < 72) begin
				// step back so remembered stamps lie in the future
				step = {$urandom, $urandom} % (span + 64'd1);
				clock_now = clock_now - step[ecdf_pkg::TS_W-1:0];
			end else if (r < 87) begin
				case ($urandom_range(0, 2))
					0: c = c ^ (32'd1 << $urandom_range(0, 31));
					1: t = t ^ (32'd1 << $urandom_range(0, 31));
					default: k = ~k;
				endcase
			end
			if (r >= 87) begin
				stamp = rand_stamp();
				send_event($urandom, $urandom, 1'($urandom_range(0, 1)), stamp);
			end else begin
				send_event(c, t, k, clock_now);
				pool_last[p] = clock_now;
			end
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	// Result side: random ready, or one long counted hold-off on request
	initial begin : result_sink
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				stall = rx_quiet ? 0 : pick_gap();
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Compare each result beat with the oldest owed allow bit
	always @(posedge clk) begin
		logic exp_allow;
		if (arst_n && m_tvalid && m_tready) begin
			if (allow_due.size() == 0) begin
				$error("allow: result beat 0x%0h with no event pending", m_tdata);
				err_count++;
			end else begin
				exp_allow = allow_due.pop_front();
				if (m_tdata[0] !== exp_allow) begin
					$error("allow: expected %0b, got %0b", exp_allow, m_tdata[0]);
					err_count++;
				end
				if (exp_allow)
					allowed_cnt++;
				else
					suppressed_cnt++;
			end
		end
	end

	// Watchdog: end the run if no beat moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			dead_cycles <= 0;
		else
			dead_cycles <= dead_cycles + 1;
		if (dead_cycles >= STALL_LIMIT) begin
			$display("event_cooldown_dedup_filter_top_tb: done, errors");
			$finish;
		end
	end

	initial begin : test_sequence
		logic [ecdf_pkg::COOL_W-1:0] short_window;
		logic [ecdf_pkg::COOL_W-1:0] mid_window;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		arst_n       = 1'b0;
		err_count    = 0;
		sent_cnt     = 0;
		allowed_cnt  = 0;
		suppressed_cnt = 0;
		window_cnt   = 0;
		dead_cycles  = 0;
		tx_quiet     = 1'b0;
		rx_quiet     = 1'b0;
		hold_req     = 1'b0;
		for (int i = 0; i < RING_DEPTH; i++)
			seen_events[i] = '0;
		seen_wr_ptr  = 0;
		cooldown_win = ecdf_pkg::COOL_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_window();
		test_zero_window();
		test_max_window();
		test_output_backpressure();

		short_window = 48'($urandom_range(1, 300));
		mid_window   = {16'($urandom_range(0, 65535)), 32'($urandom)};
		test_random_traffic(48'd7000, 150, 1'b0);
		test_random_traffic(short_window, 150, 1'b0);
		test_random_traffic(COOL_MAX, 130, 1'b1);
		test_random_traffic('0, 110, 1'b0);
		test_random_traffic(mid_window, 110, 1'b0);

		// Let every owed result arrive, then watch for strays
		s_tvalid <= 1'b0;
		while (allow_due.size() != 0)
			@(posedge clk);
		repeat (RING_DEPTH + 8) @(posedge clk);

		$display("Checked %0d events (%0d allowed, %0d suppressed) over %0d window writes,",
			sent_cnt, allowed_cnt, suppressed_cnt, window_cnt);
		$display("including zero and widest windows and a %0d-cycle output hold-off.",
			HOLD_CYCLES);
		if (err_count == 0)
			$display("event_cooldown_dedup_filter_top_tb: done, clean");
		else
			$display("event_cooldown_dedup_filter_top_tb: done, errors");
		$finish;
	end

endmodule
